>>> hdl/thk_pkg.sv
// shared constants, codes and transfer types of the thick line rasterizer
`default_nettype none

package thk_pkg;

   // coordinate and field widths
   localparam int COORD_BITS  = 12;
   localparam int EBITS       = COORD_BITS + 2;
   localparam int SCREEN_BITS = 11;
   localparam int PEN_BITS    = 8;
   localparam int COLOR_BITS  = 16;
   localparam int CMP_BITS    = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 1;

   // configuration port
   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;
   localparam logic [SCREEN_BITS-1:0] SCREEN_RESET = SCREEN_BITS'(240);

   typedef logic [COORD_BITS-1:0] coord_type;

   // request codes
   typedef enum logic {
      REQ_START = 1'b0,
      REQ_STEP  = 1'b1
   } req_code_type;

   // register indexes
   typedef enum logic {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } reg_index_type;

   // classified command from the front to the back
   typedef struct packed {
      logic                  is_start;
      coord_type             x0;
      coord_type             y0;
      coord_type             x1;
      coord_type             y1;
      coord_type             dx;
      coord_type             dy;
      logic                  sx_neg;
      logic                  sy_neg;
      logic [EBITS-1:0]      err;
      logic [PEN_BITS-1:0]   pen;
      logic [COLOR_BITS-1:0] color;
   } cmd_type;

   // rectangle result
   typedef struct packed {
      coord_type             x;
      coord_type             y;
      coord_type             w;
      coord_type             h;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } rect_type;

   // queue status seen by the producer and consumer
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

`default_nettype wire

>>> hdl/thk_front.sv
// front stage: accepts requests, classifies them and precomputes line setup
`default_nettype none

module thk_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic                                  req_type,
   input  wire logic signed [thk_pkg::COORD_BITS-1:0] req_start_x,
   input  wire logic signed [thk_pkg::COORD_BITS-1:0] req_start_y,
   input  wire logic signed [thk_pkg::COORD_BITS-1:0] req_end_x,
   input  wire logic signed [thk_pkg::COORD_BITS-1:0] req_end_y,
   input  wire logic        [thk_pkg::PEN_BITS-1:0]   req_pen_size,
   input  wire logic        [thk_pkg::COLOR_BITS-1:0] req_pen_color,
   input  wire thk_pkg::queue_stat_type               q_stat,
   output logic                                       q_push,
   output thk_pkg::cmd_type                           q_cmd
);

   logic                               vld_ff, vld_in;
   thk_pkg::cmd_type                   cmd_ff, cmd_in;
   logic                               ready;
   logic                               take;
   logic signed [thk_pkg::COORD_BITS:0] ddx, ddy;
   logic        [thk_pkg::COORD_BITS:0] adx, ady;
   thk_pkg::coord_type                 dx, dy;
   logic        [thk_pkg::EBITS-1:0]   half_dx, half_dy;

   // handshake: hold the stage while the queue is full
   assign ready  = !vld_ff || !q_stat.full;
   assign full   = !ready;
   assign take   = push && ready;
   assign q_push = vld_ff && !q_stat.full;
   assign q_cmd  = cmd_ff;

   // absolute deltas and initial error
   always_comb begin
      ddx     = {req_end_x[thk_pkg::COORD_BITS-1], req_end_x}
              - {req_start_x[thk_pkg::COORD_BITS-1], req_start_x};
      ddy     = {req_end_y[thk_pkg::COORD_BITS-1], req_end_y}
              - {req_start_y[thk_pkg::COORD_BITS-1], req_start_y};
      adx     = ddx[thk_pkg::COORD_BITS] ? -ddx : ddx;
      ady     = ddy[thk_pkg::COORD_BITS] ? -ddy : ddy;
      dx      = adx[thk_pkg::COORD_BITS-1:0];
      dy      = ady[thk_pkg::COORD_BITS-1:0];
      half_dx = {3'b000, dx[thk_pkg::COORD_BITS-1:1]};
      half_dy = {3'b000, dy[thk_pkg::COORD_BITS-1:1]};
   end

   // build the command
   always_comb begin
      cmd_in          = cmd_ff;
      vld_in          = vld_ff;
      if (q_push) begin
         vld_in = 1'b0;
      end
      if (take) begin
         vld_in          = 1'b1;
         cmd_in.is_start = (req_type == thk_pkg::REQ_START);
         cmd_in.x0       = req_start_x;
         cmd_in.y0       = req_start_y;
         cmd_in.x1       = req_end_x;
         cmd_in.y1       = req_end_y;
         cmd_in.dx       = dx;
         cmd_in.dy       = dy;
         cmd_in.sx_neg   = !(req_start_x < req_end_x);
         cmd_in.sy_neg   = !(req_start_y < req_end_y);
         cmd_in.err      = (dx > dy) ? half_dx : (thk_pkg::EBITS'(0) - half_dy);
         cmd_in.pen      = (req_pen_size == '0) ? thk_pkg::PEN_BITS'(1) : req_pen_size;
         cmd_in.color    = req_pen_color;
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

`default_nettype wire

>>> hdl/thk_queue.sv
// two-entry command queue between front and back
`default_nettype none

module thk_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire thk_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output thk_pkg::cmd_type      head,
   output thk_pkg::queue_stat_type stat
);

   thk_pkg::cmd_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign stat.full  = (cnt_ff == 2'd2);
   assign stat.empty = (cnt_ff == 2'd0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> hdl/thk_back.sv
// back stage: line state, bresenham stepping and result buffer
`default_nettype none

module thk_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [thk_pkg::SCREEN_BITS-1:0] screen_width,
   input  wire thk_pkg::cmd_type                head,
   input  wire thk_pkg::queue_stat_type         q_stat,
   output logic                                 q_pop,
   input  wire logic                            pop,
   output logic                                 empty,
   output thk_pkg::rect_type                    rsp
);

   // line state
   thk_pkg::coord_type                cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   thk_pkg::coord_type                goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   thk_pkg::coord_type                dx_ff, dx_in, dy_ff, dy_in;
   logic                              sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic [thk_pkg::EBITS-1:0]         err_ff, err_in;
   logic [thk_pkg::PEN_BITS-1:0]      pen_ff, pen_in;
   logic [thk_pkg::COLOR_BITS-1:0]    color_ff, color_in;
   logic                              active_ff, active_in;

   // result buffer
   thk_pkg::rect_type                 obuf_ff [2];
   logic                              owr_ff, owr_in, ord_ff, ord_in;
   logic [1:0]                        ocnt_ff, ocnt_in;
   logic                              opush, opop;

   logic                              take;
   logic                              res_vld;
   thk_pkg::rect_type                 res;
   logic signed [thk_pkg::EBITS:0]    e_ext, dx_s, dy_s;
   logic                              go_x, go_y, skip_y;
   thk_pkg::coord_type                nx, ny;
   logic [thk_pkg::EBITS-1:0]         acc;
   thk_pkg::coord_type                pen_w;

   assign take  = !q_stat.empty && (ocnt_ff != 2'd2);
   assign q_pop = take;

   // one bresenham step or a start setup per command
   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      err_in    = err_ff;
      pen_in    = pen_ff;
      color_in  = color_ff;
      active_in = active_ff;
      res_vld   = 1'b0;
      pen_w     = thk_pkg::COORD_BITS'(pen_ff);
      res.x     = cur_x_ff;
      res.y     = cur_y_ff;
      res.w     = pen_w;
      res.h     = pen_w;
      res.color = color_ff;
      res.last  = 1'b0;

      e_ext  = {err_ff[thk_pkg::EBITS-1], err_ff};
      dx_s   = (thk_pkg::EBITS+1)'(dx_ff);
      dy_s   = (thk_pkg::EBITS+1)'(dy_ff);
      go_x   = e_ext > -dx_s;
      go_y   = e_ext < dy_s;
      nx     = cur_x_ff;
      ny     = cur_y_ff;
      acc    = err_ff;
      skip_y = 1'b0;
      if (go_x) begin
         acc    = acc - thk_pkg::EBITS'(dy_ff);
         nx     = cur_x_ff + (sx_neg_ff ? '1 : thk_pkg::COORD_BITS'(1));
         skip_y = nx[thk_pkg::COORD_BITS-1]
               || (thk_pkg::CMP_BITS'(nx) > thk_pkg::CMP_BITS'(screen_width));
      end
      if (!skip_y && go_y) begin
         acc = acc + thk_pkg::EBITS'(dx_ff);
         ny  = cur_y_ff + (sy_neg_ff ? '1 : thk_pkg::COORD_BITS'(1));
      end

      if (take) begin
         if (head.is_start) begin
            cur_x_in  = head.x0;
            cur_y_in  = head.y0;
            goal_x_in = head.x1;
            goal_y_in = head.y1;
            dx_in     = head.dx;
            dy_in     = head.dy;
            sx_neg_in = head.sx_neg;
            sy_neg_in = head.sy_neg;
            err_in    = head.err;
            pen_in    = head.pen;
            color_in  = head.color;
            res.x     = head.x0;
            res.y     = head.y0;
            res.color = head.color;
            res.last  = 1'b1;
            if (head.x0 == head.x1) begin
               // vertical or single point
               res_vld   = 1'b1;
               active_in = 1'b0;
               res.w     = thk_pkg::COORD_BITS'(head.pen);
               res.h     = head.dy;
            end else if (head.y0 == head.y1) begin
               // horizontal
               res_vld   = 1'b1;
               active_in = 1'b0;
               res.w     = head.dx;
               res.h     = thk_pkg::COORD_BITS'(head.pen);
            end else begin
               active_in = 1'b1;
            end
         end else if (active_ff) begin
            res_vld  = 1'b1;
            cur_x_in = nx;
            cur_y_in = ny;
            err_in   = acc;
            res.last = (nx == goal_x_ff) && (ny == goal_y_ff);
            if (res.last) begin
               active_in = 1'b0;
            end
         end
      end
   end

   // result buffer bookkeeping
   assign opush = take && res_vld;
   assign opop  = pop && (ocnt_ff != 2'd0);
   assign empty = (ocnt_ff == 2'd0);
   assign rsp   = obuf_ff[ord_ff];

   always_comb begin
      owr_in  = owr_ff ^ opush;
      ord_in  = ord_ff ^ opop;
      ocnt_in = ocnt_ff + {1'b0, opush} - {1'b0, opop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         owr_ff    <= 1'b0;
         ord_ff    <= 1'b0;
         ocnt_ff   <= 2'd0;
      end else begin
         active_ff <= active_in;
         owr_ff    <= owr_in;
         ord_ff    <= ord_in;
         ocnt_ff   <= ocnt_in;
      end
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      goal_x_ff <= goal_x_in;
      goal_y_ff <= goal_y_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
      err_ff    <= err_in;
      pen_ff    <= pen_in;
      color_ff  <= color_in;
      if (opush) begin
         obuf_ff[owr_ff] <= res;
      end
   end

endmodule

`default_nettype wire

>>> hdl/thick_line_rasterizer_unit.sv
// top level of the thick line rasterizer: front, queue, back and registers
//
// channel   ports                          transfer when
// request   push, full, req_*              push && !full
// result    empty, pop, rsp_*              pop && !empty
// config    psel, penable, pwrite, paddr,  psel && penable && pwrite (pready tied high)
//           pwdata, prdata, pready
//
// one request per cycle is taken when the result side keeps popping; the back
// stage retires one command per cycle, while its result buffer has room, with a single add/compare step.
// a request passes the front register and the command queue write, then the back
// stage writing the result buffer, before its result shows on the result ports
// reset is synchronous and active high; it empties both queues and idles the line.
// a stalled result side fills the result buffer, then the command queue and the
// front register, then raises full
`default_nettype none

module thick_line_rasterizer_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic                                  req_type,
   input  wire logic signed [thk_pkg::COORD_BITS-1:0] req_start_x,
   input  wire logic signed [thk_pkg::COORD_BITS-1:0] req_start_y,
   input  wire logic signed [thk_pkg::COORD_BITS-1:0] req_end_x,
   input  wire logic signed [thk_pkg::COORD_BITS-1:0] req_end_y,
   input  wire logic        [thk_pkg::PEN_BITS-1:0]   req_pen_size,
   input  wire logic        [thk_pkg::COLOR_BITS-1:0] req_pen_color,
   output logic                                       empty,
   input  wire logic                                  pop,
   output logic signed [thk_pkg::COORD_BITS-1:0]      rsp_rect_x,
   output logic signed [thk_pkg::COORD_BITS-1:0]      rsp_rect_y,
   output logic        [thk_pkg::COORD_BITS-1:0]      rsp_rect_w,
   output logic        [thk_pkg::COORD_BITS-1:0]      rsp_rect_h,
   output logic        [thk_pkg::COLOR_BITS-1:0]      rsp_rect_color,
   output logic                                       rsp_last_rect,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic        [thk_pkg::ADDR_BITS-1:0]  paddr,
   input  wire logic        [thk_pkg::DATA_BITS-1:0]  pwdata,
   output logic             [thk_pkg::DATA_BITS-1:0]  prdata,
   output logic                                       pready
);

   logic [thk_pkg::SCREEN_BITS-1:0] width_ff, width_in;
   logic [thk_pkg::SCREEN_BITS-1:0] height_ff, height_in;
   thk_pkg::reg_index_type          reg_idx;
   logic                            csr_wr;

   thk_pkg::queue_stat_type         q_stat;
   logic                            q_push, q_pop;
   thk_pkg::cmd_type                q_cmd, q_head;
   thk_pkg::rect_type               rsp;

   // register decode
   assign pready  = 1'b1;
   assign reg_idx = thk_pkg::reg_index_type'(paddr[2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      prdata    = '0;
      unique case (reg_idx)
         thk_pkg::REG_SCREEN_WIDTH: begin
            prdata = thk_pkg::DATA_BITS'(width_ff);
            if (csr_wr) begin
               width_in = pwdata[thk_pkg::SCREEN_BITS-1:0];
            end
         end
         thk_pkg::REG_SCREEN_HEIGHT: begin
            prdata = thk_pkg::DATA_BITS'(height_ff);
            if (csr_wr) begin
               height_in = pwdata[thk_pkg::SCREEN_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= thk_pkg::SCREEN_RESET;
         height_ff <= thk_pkg::SCREEN_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // front
   thk_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_type      (req_type),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_pen_size  (req_pen_size),
      .req_pen_color (req_pen_color),
      .q_stat        (q_stat),
      .q_push        (q_push),
      .q_cmd         (q_cmd)
   );

   // command queue
   thk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .stat     (q_stat)
   );

   // back
   thk_back u_back (
      .clock        (clock),
      .reset        (reset),
      .screen_width (width_ff),
      .head         (q_head),
      .q_stat       (q_stat),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .rsp          (rsp)
   );

   // result ports
   assign rsp_rect_x     = rsp.x;
   assign rsp_rect_y     = rsp.y;
   assign rsp_rect_w     = rsp.w;
   assign rsp_rect_h     = rsp.h;
   assign rsp_rect_color = rsp.color;
   assign rsp_last_rect  = rsp.last;

endmodule

`default_nettype wire

>>> hdl/thk_checker.sv
// port-level checker for the thick line rasterizer and its bind
`default_nettype none

module thk_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             full,
   input wire logic                             empty,
   input wire logic                             pop,
   input wire logic [thk_pkg::COORD_BITS-1:0]   rsp_rect_x,
   input wire logic [thk_pkg::COORD_BITS-1:0]   rsp_rect_w,
   input wire logic [thk_pkg::COORD_BITS-1:0]   rsp_rect_h,
   input wire logic                             rsp_last_rect,
   input wire logic                             pready
);

   // reset leaves both sides idle
   assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not cleared by reset");

   // the register port never waits
   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

   // a waiting result is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_rect_x)))
      else $error("waiting result lost or changed");

   // step rectangles are square pen stamps of at least one pixel
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_last_rect) |-> ((rsp_rect_w == rsp_rect_h) && (rsp_rect_w != '0)))
      else $error("step rectangle not a square pen");

endmodule

bind thick_line_rasterizer_unit thk_checker u_thk_checker (.*);

`default_nettype wire

>>> tb/rect_scoreboard_pkg.sv
// scoreboard class: line engine prediction and rectangle checking
`timescale 1ns / 100ps

package rect_scoreboard_pkg;
   import thk_pkg::*;

   class rect_scoreboard;
      // register copies
      logic [SCREEN_BITS-1:0] screen_width;
      logic [SCREEN_BITS-1:0] screen_height;
      // line engine copy
      coord_type              cur_x, cur_y, goal_x, goal_y, delta_x, delta_y;
      logic                   step_x_neg, step_y_neg;
      logic [EBITS-1:0]       error_acc;
      logic [PEN_BITS-1:0]    pen_edge;
      logic [COLOR_BITS-1:0]  ink_color;
      bit                     line_active;
      // rectangles still owed by the block
      rect_type               expected_rects[$];
      // counters
      int                     failures;
      int                     rects_checked;
      int                     useful_items;
      int                     lines_started;
      int                     steps_taken;
      int                     clipped_steps;
      int                     csr_writes;

      function new();
         screen_width  = SCREEN_RESET;
         screen_height = SCREEN_RESET;
         cur_x = '0; cur_y = '0; goal_x = '0; goal_y = '0;
         delta_x = '0; delta_y = '0;
         step_x_neg = 1'b0; step_y_neg = 1'b0;
         error_acc = '0;
         pen_edge = PEN_BITS'(1);
         ink_color = '0;
         line_active = 1'b0;
         failures = 0; rects_checked = 0; useful_items = 0;
         lines_started = 0; steps_taken = 0; clipped_steps = 0; csr_writes = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [DATA_BITS-1:0] value);
         csr_writes++;
         if (idx == REG_SCREEN_WIDTH)
            screen_width = value[SCREEN_BITS-1:0];
         else
            screen_height = value[SCREEN_BITS-1:0];
      endfunction

      function void owe_rect(coord_type x, coord_type y, coord_type w, coord_type h, bit last);
         rect_type r;
         r.x = x; r.y = y; r.w = w; r.h = h;
         r.color = ink_color;
         r.last = last;
         expected_rects.push_back(r);
      endfunction

      // one accepted request: update the engine and queue what it owes
      function void note_request(req_code_type kind, coord_type sx, coord_type sy,
                                 coord_type ex, coord_type ey,
                                 logic [PEN_BITS-1:0] pen, logic [COLOR_BITS-1:0] color);
         int  x0, y0, x1, y1, dx, dy, e, acc, nx;
         bit  skip_y, last;
         coord_type ox, oy;
         if (kind == REQ_START) begin
            x0 = $signed(sx); y0 = $signed(sy);
            x1 = $signed(ex); y1 = $signed(ey);
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            e  = ((dx > dy) ? dx : -dy) / 2;
            cur_x = sx; cur_y = sy; goal_x = ex; goal_y = ey;
            delta_x = dx[COORD_BITS-1:0];
            delta_y = dy[COORD_BITS-1:0];
            step_x_neg = !(x0 < x1);
            step_y_neg = !(y0 < y1);
            error_acc = e[EBITS-1:0];
            pen_edge = (pen == '0) ? PEN_BITS'(1) : pen;
            ink_color = color;
            useful_items++;
            lines_started++;
            // vertical and single point lines, then horizontal ones
            if (x0 == x1) begin
               line_active = 1'b0;
               owe_rect(cur_x, cur_y, COORD_BITS'(pen_edge), delta_y, 1'b1);
            end else if (y0 == y1) begin
               line_active = 1'b0;
               owe_rect(cur_x, cur_y, delta_x, COORD_BITS'(pen_edge), 1'b1);
            end else begin
               line_active = 1'b1;
            end
            return;
         end
         // step while idle is ignored
         if (!line_active)
            return;
         useful_items++;
         steps_taken++;
         e   = $signed(error_acc);
         dx  = delta_x;
         dy  = delta_y;
         acc = e;
         ox  = cur_x;
         oy  = cur_y;
         skip_y = 1'b0;
         if (e > -dx) begin
            acc = acc - dy;
            cur_x = cur_x + (step_x_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
            nx = $signed(cur_x);
            if (nx < 0 || nx > int'(screen_width))
               skip_y = 1'b1;
         end
         if (skip_y)
            clipped_steps++;
         if (!skip_y && e < dy) begin
            acc = acc + dx;
            cur_y = cur_y + (step_y_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
         end
         error_acc = acc[EBITS-1:0];
         last = (cur_x == goal_x) && (cur_y == goal_y);
         if (last)
            line_active = 1'b0;
         owe_rect(ox, oy, COORD_BITS'(pen_edge), COORD_BITS'(pen_edge), last);
      endfunction

      function void compare_field(string label, int want, int got);
         if (want != got) begin
            failures++;
            if (failures <= 40)
               $display("%0t: %s expected %0d (0x%0h) got %0d (0x%0h)",
                        $time, label, want, want, got, got);
         end
      endfunction

      // one result transfer from the block
      function void check_rect(coord_type x, coord_type y, coord_type w, coord_type h,
                               logic [COLOR_BITS-1:0] color, logic last);
         rect_type want;
         if (expected_rects.size() == 0) begin
            failures++;
            if (failures <= 40)
               $display("%0t: rectangle with none expected, expected nothing got x %0d y %0d",
                        $time, $signed(x), $signed(y));
            return;
         end
         want = expected_rects.pop_front();
         rects_checked++;
         compare_field("rect_x", $signed(want.x), $signed(x));
         compare_field("rect_y", $signed(want.y), $signed(y));
         compare_field("rect_w", want.w, w);
         compare_field("rect_h", want.h, h);
         compare_field("rect_color", want.color, color);
         compare_field("last_rect", want.last, last);
      endfunction
   endclass

endpackage

>>> tb/tb_top.sv
// top of the rasterizer testbench: clock, reset, drivers and run control
`timescale 1ns / 100ps

module tb_top;
   import thk_pkg::*;
   import rect_scoreboard_pkg::*;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         push = 1'b0;
   logic                         full;
   logic                         req_type = 1'b0;
   logic signed [COORD_BITS-1:0] req_start_x = '0;
   logic signed [COORD_BITS-1:0] req_start_y = '0;
   logic signed [COORD_BITS-1:0] req_end_x = '0;
   logic signed [COORD_BITS-1:0] req_end_y = '0;
   logic        [PEN_BITS-1:0]   req_pen_size = '0;
   logic        [COLOR_BITS-1:0] req_pen_color = '0;
   logic                         empty;
   logic                         pop = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_rect_x;
   logic signed [COORD_BITS-1:0] rsp_rect_y;
   logic        [COORD_BITS-1:0] rsp_rect_w;
   logic        [COORD_BITS-1:0] rsp_rect_h;
   logic        [COLOR_BITS-1:0] rsp_rect_color;
   logic                         rsp_last_rect;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic        [ADDR_BITS-1:0]  paddr = '0;
   logic        [DATA_BITS-1:0]  pwdata = '0;
   logic        [DATA_BITS-1:0]  prdata;
   logic                         pready;

   rect_scoreboard sb = new();

   int burst_left = 0;
   int pop_mode = 0;
   int pop_left = 0;

   thick_line_rasterizer_unit dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_type(req_type),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .req_pen_size(req_pen_size), .req_pen_color(req_pen_color),
      .empty(empty), .pop(pop),
      .rsp_rect_x(rsp_rect_x), .rsp_rect_y(rsp_rect_y),
      .rsp_rect_w(rsp_rect_w), .rsp_rect_h(rsp_rect_h),
      .rsp_rect_color(rsp_rect_color), .rsp_last_rect(rsp_last_rect),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock
   always #1 clock = ~clock;

   // run limit
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: check every transfer, pop on a changing stall pattern
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty)
            sb.check_rect(rsp_rect_x, rsp_rect_y, rsp_rect_w, rsp_rect_h,
                          rsp_rect_color, rsp_last_rect);
         if (pop_left == 0) begin
            pop_mode = $urandom_range(0, 3);
            pop_left = $urandom_range(20, 200);
         end else begin
            pop_left = pop_left - 1;
         end
         case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ((pop_left % 16) < 3);
         endcase
      end
   end

   // one request transfer, with bursts and gaps on the request side
   task automatic send_item(input req_code_type kind, input int sx, input int sy,
                            input int ex, input int ey, input int pen, input int color);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left = burst_left - 1;
      push          <= 1'b1;
      req_type      <= kind;
      req_start_x   <= COORD_BITS'(sx);
      req_start_y   <= COORD_BITS'(sy);
      req_end_x     <= COORD_BITS'(ex);
      req_end_y     <= COORD_BITS'(ey);
      req_pen_size  <= PEN_BITS'(pen);
      req_pen_color <= COLOR_BITS'(color);
      do @(posedge clock); while (full);
      sb.note_request(kind, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex),
                      COORD_BITS'(ey), PEN_BITS'(pen), COLOR_BITS'(color));
   endtask

   task automatic start_line(input int sx, input int sy, input int ex, input int ey,
                             input int pen, input int color);
      send_item(REQ_START, sx, sy, ex, ey, pen, color);
   endtask

   // a step carries random fields that the engine must ignore
   task automatic step_line();
      send_item(REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic step_until_done(input int cap);
      int n;
      n = 0;
      while (sb.line_active && n < cap) begin
         step_line();
         n++;
      end
   endtask

   // hold requests until every owed rectangle is out, then optionally settle
   task automatic drain_results(input bit settle);
      push <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.expected_rects.size() != 0);
      if (settle)
         repeat (32) @(posedge clock);
   endtask

   // register write: setup then access, upper data bits sometimes random
   task automatic write_csr(input reg_index_type idx, input int value);
      logic [DATA_BITS-1:0] word;
      word = ($urandom_range(0, 1) == 0) ? '0 : $urandom;
      word[SCREEN_BITS-1:0] = SCREEN_BITS'(value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_BITS'(4 * int'(idx));
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_register(idx, word);
   endtask

   // one random line: mostly short lines near the screen, mostly run to the end
   task automatic run_random_line();
      int r, x0, y0, x1, y1, pen, cap;
      r = $urandom_range(0, 15);
      if (r == 0) begin
         x0 = $urandom; y0 = $urandom; x1 = $urandom; y1 = $urandom;
      end else begin
         x0 = $urandom_range(0, int'(sb.screen_width) + 40) - 20;
         y0 = $urandom_range(0, int'(sb.screen_height) + 40) - 20;
         x1 = x0 + $urandom_range(0, 60) - 30;
         y1 = y0 + $urandom_range(0, 60) - 30;
         if (r == 1) x1 = x0;
         if (r == 2) y1 = y0;
      end
      pen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 255);
      start_line(x0, y0, x1, y1, pen, $urandom);
      if (r == 0)
         cap = $urandom_range(1, 40);
      else if ($urandom_range(0, 4) == 0)
         cap = $urandom_range(0, 8);
      else
         cap = 150;
      step_until_done(cap);
      // occasional steps after the line is gone or cut short
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) step_line();
   endtask

   initial begin
      int phase, target, w, h;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset register values
      start_line(5, 5, 5, 20, 0, 0);                       // vertical, pen zero
      start_line(-2048, -2048, -2048, -2048, 255, 'hFFFF);  // single point
      start_line(2047, 7, -2048, 7, 255, 'h1234);          // widest horizontal
      start_line(0, 2047, 0, -2048, 1, 'h8001);            // tallest vertical
      step_line();                                         // step while idle
      start_line(0, 0, 4, 3, 3, 'hF800);                   // short diagonal
      step_until_done(10);
      start_line(10, 10, 20, 30, 4, 'h07E0);
      step_line();
      step_line();
      start_line(-2, 0, 3, 2, 2, 'h001F);                  // restart, left clip
      step_until_done(20);
      start_line(238, 0, 245, 3, 6, 'hAAAA);               // right clip
      step_until_done(20);
      start_line(-2048, -2048, 2047, 2047, 200, 'h5555);   // extreme diagonal
      repeat (3) step_line();
      start_line(100, 100, 90, 95, 9, 'hC3C3);             // negative steps
      step_until_done(20);
      step_line();

      // random phases over several screen settings
      for (phase = 0; phase < 6; phase++) begin
         drain_results(1'b1);
         case (phase)
            0: begin w = 1;    h = 2047; end
            1: begin w = 2047; h = 1;    end
            2: begin w = 240;  h = 240;  end
            3: begin w = 64;   h = $urandom_range(1, 2047); end
            default: begin
               w = $urandom_range(1, 2047);
               h = $urandom_range(1, 2047);
            end
         endcase
         write_csr(REG_SCREEN_WIDTH, w);
         write_csr(REG_SCREEN_HEIGHT, h);
         target = sb.useful_items + 270;
         while (sb.useful_items < target) begin
            run_random_line();
            if ($urandom_range(0, 39) == 0)
               drain_results(1'b0);
         end
      end

      drain_results(1'b1);
      $display("covered %0d requests: %0d lines started, %0d steps, %0d rectangles checked",
               sb.useful_items, sb.lines_started, sb.steps_taken, sb.rects_checked);
      $display("%0d register writes, %0d steps with the row move dropped by the column clip",
               sb.csr_writes, sb.clipped_steps);
      if (sb.failures == 0 && sb.expected_rects.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
